// ===== rtl/core/rlcf_pkg.sv =====
package rlcf_pkg;

    localparam logic [7:0] LEVEL_MAX     = 8'd255;
    localparam logic [7:0] TICKS_RESET   = 8'd100;
    localparam logic [7:0] TIMEOUT_RESET = 8'd255;

    localparam int KIND_W  = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [KIND_W-1:0] KIND_TICK = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SET  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FADE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SWAP = 3'd3;
    localparam logic [KIND_W-1:0] KIND_STOP = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_COMMON_ANODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_STEP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_STEPS  = 2'd2;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } color_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        color_t            first;
        color_t            second;
    } item_t;

    typedef struct packed {
        color_t duty;
        logic   busy;
    } result_t;

    typedef struct packed {
        logic                  write_en;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_write_t;

    function automatic logic [7:0] to_duty(input logic [7:0] level, input logic anode);
        return anode ? 8'(LEVEL_MAX - level) : level;
    endfunction

endpackage

// ===== rtl/core/rlcf_in_stage.sv =====
module rlcf_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  rlcf_pkg::item_t in_item,
    input  logic            down_ready,
    output logic            item_fire,
    output rlcf_pkg::item_t item
);

    logic            valid_reg;
    logic            valid_next;
    rlcf_pkg::item_t item_reg;
    logic            load;

    assign item_fire = valid_reg && down_ready;
    assign in_stall  = valid_reg && !down_ready;
    assign load      = in_valid && !in_stall;
    assign item      = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (item_fire)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= in_item;
        end
    end

endmodule

// ===== rtl/core/rlcf_engine.sv =====
module rlcf_engine (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rlcf_pkg::cfg_write_t cfg,
    input  logic                 item_fire,
    input  rlcf_pkg::item_t      item,
    output rlcf_pkg::result_t    result
);

    logic            anode_reg;
    logic [7:0]      tps_reg;
    logic [7:0]      timeout_reg;

    logic [7:0]      duty_reg [3];
    logic [7:0]      duty_next [3];
    logic [7:0]      tick_reg;
    logic [7:0]      tick_next;
    logic [7:0]      step_reg;
    logic [7:0]      step_next;
    logic [2:0]      done_reg;
    logic [2:0]      done_next;
    rlcf_pkg::color_t target0_reg;
    rlcf_pkg::color_t target0_next;
    rlcf_pkg::color_t target1_reg;
    rlcf_pkg::color_t target1_next;
    logic            running_reg;
    logic            running_next;
    logic            swap_reg;
    logic            swap_next;
    logic            select_reg;
    logic            select_next;

    rlcf_pkg::color_t target;
    logic [7:0]      goal [3];
    logic [7:0]      level [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            anode_reg   <= 1'b0;
            tps_reg     <= rlcf_pkg::TICKS_RESET;
            timeout_reg <= rlcf_pkg::TIMEOUT_RESET;
        end
        else if (cfg.write_en)
        begin
            unique case (cfg.index)
                rlcf_pkg::CFG_COMMON_ANODE:   anode_reg   <= cfg.data[0];
                rlcf_pkg::CFG_TICKS_PER_STEP: tps_reg     <= cfg.data;
                rlcf_pkg::CFG_TIMEOUT_STEPS:  timeout_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    assign target  = select_reg ? target1_reg : target0_reg;
    assign goal[0] = target.red;
    assign goal[1] = target.green;
    assign goal[2] = target.blue;

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            duty_next[ch] = duty_reg[ch];
            level[ch]     = rlcf_pkg::to_duty(duty_reg[ch], anode_reg);
        end
        tick_next    = tick_reg;
        step_next    = step_reg;
        done_next    = done_reg;
        target0_next = target0_reg;
        target1_next = target1_reg;
        running_next = running_reg;
        swap_next    = swap_reg;
        select_next  = select_reg;

        if (item_fire)
        begin
            unique case (item.kind)
                rlcf_pkg::KIND_TICK:
                begin
                    if (running_reg)
                    begin
                        tick_next = 8'(tick_reg + 8'd1);
                        if (tick_next == tps_reg)
                        begin
                            step_next = 8'(step_reg + 8'd1);
                            tick_next = '0;
                            for (int ch = 0; ch < 3; ch++)
                            begin
                                if (level[ch] < goal[ch])
                                begin
                                    duty_next[ch] = rlcf_pkg::to_duty(
                                        8'(level[ch] + 8'd1), anode_reg);
                                end
                                else if (level[ch] > goal[ch])
                                begin
                                    duty_next[ch] = rlcf_pkg::to_duty(
                                        8'(level[ch] - 8'd1), anode_reg);
                                end
                                else
                                begin
                                    done_next[2-ch] = 1'b1;
                                end
                            end
                        end
                        if (done_next == 3'b111 || step_next == timeout_reg)
                        begin
                            if (swap_reg)
                            begin
                                select_next = !select_reg;
                                tick_next   = '0;
                                step_next   = '0;
                                done_next   = '0;
                            end
                            else
                            begin
                                running_next = 1'b0;
                            end
                        end
                    end
                end
                rlcf_pkg::KIND_SET:
                begin
                    duty_next[0] = rlcf_pkg::to_duty(item.first.red, anode_reg);
                    duty_next[1] = rlcf_pkg::to_duty(item.first.green, anode_reg);
                    duty_next[2] = rlcf_pkg::to_duty(item.first.blue, anode_reg);
                end
                rlcf_pkg::KIND_FADE:
                begin
                    target0_next = item.first;
                    select_next  = 1'b0;
                    swap_next    = 1'b0;
                    running_next = 1'b1;
                    tick_next    = '0;
                    step_next    = '0;
                    done_next    = '0;
                end
                rlcf_pkg::KIND_SWAP:
                begin
                    target0_next = item.first;
                    target1_next = item.second;
                    select_next  = 1'b0;
                    swap_next    = 1'b1;
                    running_next = 1'b1;
                    tick_next    = '0;
                    step_next    = '0;
                    done_next    = '0;
                end
                rlcf_pkg::KIND_STOP:
                begin
                    swap_next    = 1'b0;
                    running_next = 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                duty_reg[ch] <= '0;
            end
            tick_reg    <= '0;
            step_reg    <= '0;
            done_reg    <= '0;
            target0_reg <= '0;
            target1_reg <= '0;
            running_reg <= 1'b0;
            swap_reg    <= 1'b0;
            select_reg  <= 1'b0;
        end
        else
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                duty_reg[ch] <= duty_next[ch];
            end
            tick_reg    <= tick_next;
            step_reg    <= step_next;
            done_reg    <= done_next;
            target0_reg <= target0_next;
            target1_reg <= target1_next;
            running_reg <= running_next;
            swap_reg    <= swap_next;
            select_reg  <= select_next;
        end
    end

    assign result.duty.red   = duty_next[0];
    assign result.duty.green = duty_next[1];
    assign result.duty.blue  = duty_next[2];
    assign result.busy       = running_next;

endmodule

// ===== rtl/core/rlcf_out_stage.sv =====
module rlcf_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_fire,
    input  rlcf_pkg::result_t result,
    output logic              down_ready,
    output logic              out_valid,
    input  logic              out_stall,
    output rlcf_pkg::result_t out_result
);

    logic              valid_reg;
    logic              valid_next;
    rlcf_pkg::result_t result_reg;

    assign down_ready = !valid_reg || !out_stall;
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (item_fire)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_fire)
        begin
            result_reg <= result;
        end
    end

endmodule

// ===== rtl/core/rgb_led_color_fader.sv =====
// RGB LED colour fader: takes one item per clock while in_stall is low and returns one result per item,
// holding the item in an input register and its result in a result register, which together
// let one new item enter while a finished result waits; the state update of each item is a
// single pass of compare, increment and decrement logic between those two registers.
module rgb_led_color_fader (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write_en,
    input  logic [rlcf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rlcf_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [rlcf_pkg::KIND_W-1:0]       kind,
    input  logic [7:0]                        first_red,
    input  logic [7:0]                        first_green,
    input  logic [7:0]                        first_blue,
    input  logic [7:0]                        second_red,
    input  logic [7:0]                        second_green,
    input  logic [7:0]                        second_blue,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [7:0]                        red_duty,
    output logic [7:0]                        green_duty,
    output logic [7:0]                        blue_duty,
    output logic                              busy_res
);

    rlcf_pkg::item_t      in_item;
    rlcf_pkg::item_t      item;
    rlcf_pkg::cfg_write_t cfg;
    rlcf_pkg::result_t    result;
    rlcf_pkg::result_t    out_result;
    logic                 item_fire;
    logic                 down_ready;

    assign in_item.kind         = kind;
    assign in_item.first.red    = first_red;
    assign in_item.first.green  = first_green;
    assign in_item.first.blue   = first_blue;
    assign in_item.second.red   = second_red;
    assign in_item.second.green = second_green;
    assign in_item.second.blue  = second_blue;

    assign cfg.write_en = cfg_write_en;
    assign cfg.index    = cfg_index;
    assign cfg.data     = cfg_data;

    rlcf_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .down_ready (down_ready),
        .item_fire  (item_fire),
        .item       (item)
    );

    rlcf_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .item_fire (item_fire),
        .item      (item),
        .result    (result)
    );

    rlcf_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_fire  (item_fire),
        .result     (result),
        .down_ready (down_ready),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_result (out_result)
    );

    assign red_duty   = out_result.duty.red;
    assign green_duty = out_result.duty.green;
    assign blue_duty  = out_result.duty.blue;
    assign busy_res   = out_result.busy;

endmodule

// ===== rtl/core/rlcf_checker.sv =====
module rlcf_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_stall,
    input logic [rlcf_pkg::KIND_W-1:0]     kind,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic [7:0]                      red_duty,
    input logic [7:0]                      green_duty,
    input logic [7:0]                      blue_duty,
    input logic                            busy_res
);

    logic in_acc;

    assign in_acc = in_valid && !in_stall;

    // A stalled result holds still.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(red_duty)
            && $stable(green_duty) && $stable(blue_duty) && $stable(busy_res))
    else $error("stalled result changed");

    // The input side only backs up when the output side is full and stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

    // A stop item's result, once registered with no output stall in the way, shows the block idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && kind == rlcf_pkg::KIND_STOP ##1 !out_stall |=> out_valid && !busy_res)
    else $error("stop item did not end the sequence");

    // A fade or swap item's result, once registered with no output stall in the way, shows the block busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (kind == rlcf_pkg::KIND_FADE || kind == rlcf_pkg::KIND_SWAP)
            ##1 !out_stall |=> out_valid && busy_res)
    else $error("fade or swap item did not start a sequence");

endmodule

bind rgb_led_color_fader rlcf_checker u_rlcf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .red_duty   (red_duty),
    .green_duty (green_duty),
    .blue_duty  (blue_duty),
    .busy_res   (busy_res)
);
